// ===== design/cst_pkg.sv =====
// Shared types and constants for the connection slot table.
package cst_pkg;

    localparam int SLOTS   = 256;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int MAX_W   = 9;
    localparam int CMP_W   = (CNT_W > MAX_W) ? CNT_W : MAX_W;
    localparam int ADDR_W  = 32;
    localparam int SOCK_W  = 32;
    localparam int SEL_W   = 8;
    localparam int PORT_W  = 16;
    localparam int KIND_W  = 8;
    localparam int CFG_W   = 32;
    localparam int CFGI_W  = 1;
    localparam int STAT_W  = 3;

    localparam logic [CFGI_W-1:0] CFG_MAX_CONNS = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_EXEMPT    = 1'b1;

    localparam logic [MAX_W-1:0]  MAX_CONNS_RST = 9'd3;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_REG = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_FREE = 2'd0,
        PH_CONN = 2'd1,
        PH_REGD = 2'd2
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_OVER    = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOCONN  = 3'd3,
        ST_ALREADY = 3'd4
    } t_status;

    typedef struct packed {
        logic [IDX_W-1:0]  raddr;
        logic [IDX_W-1:0]  waddr;
        logic              ph_we;
        t_phase            ph_wdata;
        logic              ad_we;
        logic              sk_we;
        logic              pk_we;
        logic [ADDR_W-1:0] wd_addr;
        logic [SOCK_W-1:0] wd_sock;
        logic [PORT_W-1:0] wd_port;
        logic [KIND_W-1:0] wd_kind;
    } t_mem_req;

endpackage

// ===== design/connection_slot_table.sv =====
// Connection slot table top level: slot memories and sequencer.
//
// One word at a time. An add scans the phase/address memory once to count
// occupied slots holding the same source (SLOTS reads, one per cycle). If
// that count exceeds the limit and the source is not exempt it answers
// over-limit; else it walks the table circularly from the in-use count
// until a free slot turns up or the table proves full, one read at a time
// through the single read port of each memory. The result word sits in an
// output register, so the next word is accepted while it waits. Slot phases
// read free after reset via per-slot valid flags; no clearing pass is needed.
module connection_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cst_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [cst_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_operation,
    input  logic [cst_pkg::ADDR_W-1:0]  i_source_addr,
    input  logic [cst_pkg::SOCK_W-1:0]  i_socket_handle,
    input  logic [cst_pkg::SEL_W-1:0]   i_slot_sel,
    input  logic [cst_pkg::PORT_W-1:0]  i_peer_port,
    input  logic [cst_pkg::KIND_W-1:0]  i_client_kind,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cst_pkg::STAT_W-1:0]  o_status,
    output logic [cst_pkg::SEL_W-1:0]   o_slot_out
);
    import cst_pkg::*;

    t_mem_req          req;
    logic [1:0]        rd_phase_bits;
    logic [ADDR_W-1:0] rd_addr;

    cst_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_source_addr   (i_source_addr),
        .i_socket_handle (i_socket_handle),
        .i_slot_sel      (i_slot_sel),
        .i_peer_port     (i_peer_port),
        .i_client_kind   (i_client_kind),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_slot_out      (o_slot_out),
        .o_req           (req),
        .i_rd_phase      (t_phase'(rd_phase_bits)),
        .i_rd_addr       (rd_addr)
    );

    cst_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (req.ph_we),
        .i_waddr (req.waddr),
        .i_wdata (req.ph_wdata),
        .i_raddr (req.raddr),
        .o_rdata (rd_phase_bits)
    );

    cst_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (req.ad_we),
        .i_waddr (req.waddr),
        .i_wdata (req.wd_addr),
        .i_raddr (req.raddr),
        .o_rdata (rd_addr)
    );

    cst_ram #(.WIDTH(SOCK_W), .DEPTH(SLOTS)) u_sock_ram (
        .i_clk   (i_clk),
        .i_we    (req.sk_we),
        .i_waddr (req.waddr),
        .i_wdata (req.wd_sock),
        .i_raddr (req.raddr),
        .o_rdata ()
    );

    cst_ram #(.WIDTH(PORT_W + KIND_W), .DEPTH(SLOTS)) u_peer_ram (
        .i_clk   (i_clk),
        .i_we    (req.pk_we),
        .i_waddr (req.waddr),
        .i_wdata ({req.wd_port, req.wd_kind}),
        .i_raddr (req.raddr),
        .o_rdata ()
    );

endmodule

// ===== design/cst_ram.sv =====
// Generic single-port-write, registered-read RAM.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cst_ctrl.sv =====
// Sequencer: count pass, free-slot search, delete/register, result word.
module cst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cst_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [cst_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_operation,
    input  logic [cst_pkg::ADDR_W-1:0]  i_source_addr,
    input  logic [cst_pkg::SOCK_W-1:0]  i_socket_handle,
    input  logic [cst_pkg::SEL_W-1:0]   i_slot_sel,
    input  logic [cst_pkg::PORT_W-1:0]  i_peer_port,
    input  logic [cst_pkg::KIND_W-1:0]  i_client_kind,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cst_pkg::STAT_W-1:0]  o_status,
    output logic [cst_pkg::SEL_W-1:0]   o_slot_out,
    output cst_pkg::t_mem_req           o_req,
    input  cst_pkg::t_phase             i_rd_phase,
    input  logic [cst_pkg::ADDR_W-1:0]  i_rd_addr
);
    import cst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_CHECK,
        S_SEARCH,
        S_LOOK,
        S_DEC,
        S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_in_use, n_in_use;
    logic [MAX_W-1:0]  r_max, n_max;
    logic [ADDR_W-1:0] r_exempt, n_exempt;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic              r_rd_vld, n_rd_vld;
    logic              r_out_vld, n_out_vld;
    t_status           r_out_status, n_out_status;
    logic [SEL_W-1:0]  r_out_slot, n_out_slot;

    t_op               r_op, n_op;
    logic [ADDR_W-1:0] r_src, n_src;
    logic [SOCK_W-1:0] r_sock, n_sock;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [PORT_W-1:0] r_port, n_port;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [CNT_W-1:0]  r_iss, n_iss;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_hits, n_hits;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rd_last, n_rd_last;
    t_status           r_res_status, n_res_status;
    logic [SEL_W-1:0]  r_res_slot, n_res_slot;

    logic              issue;
    logic [IDX_W-1:0]  sel_idx;
    logic              sel_in_range;
    t_phase            rd_phase;
    t_phase            sel_phase;
    t_mem_req          req;

    assign sel_idx      = IDX_W'(r_sel);
    assign sel_in_range = (CMP_W + SEL_W)'(r_sel) < (CMP_W + SEL_W)'(SLOTS);
    assign rd_phase     = r_valid[r_rd_idx] ? i_rd_phase : PH_FREE;
    assign sel_phase    = sel_in_range ? rd_phase : PH_FREE;

    always_comb begin
        n_state      = r_state;
        n_in_use     = r_in_use;
        n_max        = r_max;
        n_exempt     = r_exempt;
        n_valid      = r_valid;
        n_out_vld    = r_out_vld && i_stall;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_op         = r_op;
        n_src        = r_src;
        n_sock       = r_sock;
        n_sel        = r_sel;
        n_port       = r_port;
        n_kind       = r_kind;
        n_iss        = r_iss;
        n_ptr        = r_ptr;
        n_hits       = r_hits;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;

        req          = '0;
        req.wd_addr  = r_src;
        req.wd_sock  = r_sock;
        req.wd_port  = r_port;
        req.wd_kind  = r_kind;
        req.ph_wdata = PH_FREE;

        issue        = 1'b0;
        n_rd_last    = (r_iss == CNT_W'(SLOTS - 1));
        n_rd_idx     = r_iss[IDX_W-1:0];

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_CONNS: n_max    = i_cfg_wdata[MAX_W-1:0];
                CFG_EXEMPT:    n_exempt = i_cfg_wdata[ADDR_W-1:0];
                default:       ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = t_op'(i_operation);
                    n_src  = i_source_addr;
                    n_sock = i_socket_handle;
                    n_sel  = i_slot_sel;
                    n_port = i_peer_port;
                    n_kind = i_client_kind;
                    n_iss  = '0;
                    n_hits = '0;
                    unique case (i_operation)
                        OP_ADD:  n_state = S_COUNT;
                        OP_DEL,
                        OP_REG:  n_state = S_LOOK;
                        default: begin
                            n_res_status = ST_OK;
                            n_res_slot   = i_slot_sel;
                            n_state      = S_RESP;
                        end
                    endcase
                end
            end
            S_COUNT: begin
                issue = (r_iss != CNT_W'(SLOTS));
                if (issue) begin
                    n_iss = r_iss + 1'b1;
                end
                if (r_rd_vld) begin
                    if (rd_phase != PH_FREE && i_rd_addr == r_src) begin
                        n_hits = r_hits + 1'b1;
                    end
                    if (r_rd_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (CMP_W'(r_hits) > CMP_W'(r_max) && r_src != r_exempt) begin
                    n_res_status = ST_OVER;
                    n_res_slot   = '0;
                    n_state      = S_RESP;
                end else begin
                    n_ptr   = (r_in_use < CNT_W'(SLOTS)) ? r_in_use[IDX_W-1:0] : '0;
                    n_iss   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                issue    = (r_iss != CNT_W'(SLOTS));
                n_rd_idx = r_ptr;
                if (issue) begin
                    n_iss = r_iss + 1'b1;
                    n_ptr = (r_ptr == IDX_W'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                end
                if (r_rd_vld) begin
                    if (rd_phase == PH_FREE) begin
                        req.waddr    = r_rd_idx;
                        req.ph_we    = 1'b1;
                        req.ph_wdata = PH_CONN;
                        req.ad_we    = 1'b1;
                        req.sk_we    = 1'b1;
                        n_in_use     = r_in_use + 1'b1;
                        n_res_status = ST_OK;
                        n_res_slot   = SEL_W'(r_rd_idx);
                        n_state      = S_RESP;
                    end else if (r_rd_last) begin
                        n_res_status = ST_FULL;
                        n_res_slot   = '0;
                        n_state      = S_RESP;
                    end
                end
            end
            S_LOOK: begin
                issue    = 1'b1;
                n_rd_idx = sel_idx;
                n_state  = S_DEC;
            end
            S_DEC: begin
                n_res_slot   = r_sel;
                n_res_status = ST_OK;
                req.waddr    = sel_idx;
                if (sel_phase == PH_FREE) begin
                    n_res_status = ST_NOCONN;
                end else if (r_op == OP_DEL) begin
                    req.ph_we    = 1'b1;
                    req.ph_wdata = PH_FREE;
                    if (r_in_use != '0) begin
                        n_in_use = r_in_use - 1'b1;
                    end
                end else if (sel_phase == PH_REGD) begin
                    n_res_status = ST_ALREADY;
                end else begin
                    req.ph_we    = 1'b1;
                    req.ph_wdata = PH_REGD;
                    req.pk_we    = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        req.raddr = n_rd_idx;
        n_rd_vld  = issue;
        if (req.ph_we) begin
            n_valid[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_in_use     <= '0;
            r_max        <= MAX_CONNS_RST;
            r_exempt     <= '0;
            r_valid      <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_out_status <= ST_OK;
            r_out_slot   <= '0;
        end else begin
            r_state      <= n_state;
            r_in_use     <= n_in_use;
            r_max        <= n_max;
            r_exempt     <= n_exempt;
            r_valid      <= n_valid;
            r_rd_vld     <= n_rd_vld;
            r_out_vld    <= n_out_vld;
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_src        <= n_src;
        r_sock       <= n_sock;
        r_sel        <= n_sel;
        r_port       <= n_port;
        r_kind       <= n_kind;
        r_iss        <= n_iss;
        r_ptr        <= n_ptr;
        r_hits       <= n_hits;
        r_rd_idx     <= n_rd_idx;
        r_rd_last    <= n_rd_last;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_vld;
    assign o_status   = r_out_status;
    assign o_slot_out = r_out_slot;
    assign o_req      = req;

endmodule

// ===== tb/cst_result_check.sv =====
// Result checker for the connection slot table: tracks slot state, predicts and compares.
module cst_result_check
    import cst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_word_valid,
    input  logic              i_word_stall,
    input  logic [1:0]        i_word_op,
    input  logic [ADDR_W-1:0] i_word_src,
    input  logic [SEL_W-1:0]  i_word_sel,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [STAT_W-1:0] i_res_status,
    input  logic [SEL_W-1:0]  i_res_slot,
    output int                o_pending,
    output int                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        logic [SEL_W-1:0] slot;
    } t_slot_answer;

    t_phase            slot_state [SLOTS];
    logic [ADDR_W-1:0] slot_src   [SLOTS];
    int                occupied;
    logic [MAX_W-1:0]  src_limit;
    logic [ADDR_W-1:0] src_exempt;
    t_slot_answer      answers_due[$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_slot_answer apply_request(
        input logic [1:0]        op,
        input logic [ADDR_W-1:0] src,
        input logic [SEL_W-1:0]  sel
    );
        t_slot_answer ans;
        t_phase       ph;
        int           same_src;
        int           pos;
        ans.status = ST_OK;
        ans.slot   = sel;
        ph = (int'(sel) < SLOTS) ? slot_state[sel] : PH_FREE;
        case (op)
            OP_ADD: begin
                ans.status = ST_FULL;
                ans.slot   = '0;
                same_src   = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_state[i] != PH_FREE && slot_src[i] == src) same_src++;
                end
                if (same_src > int'(src_limit) && src != src_exempt) begin
                    ans.status = ST_OVER;
                end else begin
                    pos = (occupied < SLOTS) ? occupied : 0;
                    for (int k = 0; k < SLOTS; k++) begin
                        if (slot_state[pos] == PH_FREE) begin
                            slot_state[pos] = PH_CONN;
                            slot_src[pos]   = src;
                            occupied++;
                            ans.status = ST_OK;
                            ans.slot   = pos[SEL_W-1:0];
                            break;
                        end
                        pos = (pos + 1) % SLOTS;
                    end
                end
            end
            OP_DEL: begin
                if (ph == PH_FREE) begin
                    ans.status = ST_NOCONN;
                end else begin
                    slot_state[sel] = PH_FREE;
                    if (occupied > 0) occupied--;
                end
            end
            OP_REG: begin
                if (ph == PH_FREE) begin
                    ans.status = ST_NOCONN;
                end else if (ph == PH_REGD) begin
                    ans.status = ST_ALREADY;
                end else begin
                    slot_state[sel] = PH_REGD;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_slot_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_state[i] = PH_FREE;
            occupied   = 0;
            src_limit  = MAX_CONNS_RST;
            src_exempt = '0;
            answers_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result word: status %0d slot_out %0d",
                           i_res_status, i_res_slot);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_res_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res_status);
                        mismatches++;
                    end
                    if (i_res_slot !== want.slot) begin
                        $error("slot_out: expected %0d, got %0d", want.slot, i_res_slot);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_CONNS: src_limit  = i_cfg_wdata[MAX_W-1:0];
                    CFG_EXEMPT:    src_exempt = i_cfg_wdata[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_word_valid && !i_word_stall) begin
                answers_due.push_back(apply_request(i_word_op, i_word_src, i_word_sel));
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

// ===== tb/tb_connection_slot_table.sv =====
// Testbench top for the connection slot table: clock, reset, stimulus and verdict.
module tb_connection_slot_table;
    import cst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         HOLD_CYCLES = 2000;
    localparam int         QUIET_LIMIT = 50000;
    localparam int         DRAIN_TAIL  = 520;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [CFGI_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]  cfg_wdata  = '0;
    logic              word_valid = 1'b0;
    logic              word_stall;
    logic [1:0]        word_op    = '0;
    logic [ADDR_W-1:0] word_src   = '0;
    logic [SOCK_W-1:0] word_sock  = '0;
    logic [SEL_W-1:0]  word_sel   = '0;
    logic [PORT_W-1:0] word_port  = '0;
    logic [KIND_W-1:0] word_kind  = '0;
    logic              res_valid;
    logic              res_stall  = 1'b0;
    logic [STAT_W-1:0] res_status;
    logic [SEL_W-1:0]  res_slot;
    int                pending;
    int                fail_count;
    int                quiet      = 0;
    logic [ADDR_W-1:0] src_pool[8];

    always #1 clk = ~clk;

    connection_slot_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_valid         (word_valid),
        .o_stall         (word_stall),
        .i_operation     (word_op),
        .i_source_addr   (word_src),
        .i_socket_handle (word_sock),
        .i_slot_sel      (word_sel),
        .i_peer_port     (word_port),
        .i_client_kind   (word_kind),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_status        (res_status),
        .o_slot_out      (res_slot)
    );

    cst_result_check result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_word_valid (word_valid),
        .i_word_stall (word_stall),
        .i_word_op    (word_op),
        .i_word_src   (word_src),
        .i_word_sel   (word_sel),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_res_status (res_status),
        .i_res_slot   (res_slot),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int idle_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    task automatic offer_word(
        input logic [1:0]        op,
        input logic [ADDR_W-1:0] src,
        input logic [SOCK_W-1:0] sock,
        input logic [SEL_W-1:0]  sel,
        input logic [PORT_W-1:0] port,
        input logic [KIND_W-1:0] kind
    );
        int gap;
        gap = idle_run_len();
        if (gap > 0) begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid <= 1'b1;
        word_op    <= op;
        word_src   <= src;
        word_sock  <= sock;
        word_sel   <= sel;
        word_port  <= port;
        word_kind  <= kind;
        @(posedge clk);
        while (word_stall) @(posedge clk);
    endtask

    task automatic random_word(input int add_pct, input int sel_hi);
        int                r;
        logic [1:0]        op;
        logic [ADDR_W-1:0] src;
        logic [SEL_W-1:0]  sel;
        r = $urandom_range(0, 99);
        if (r < add_pct) op = OP_ADD;
        else if (r < add_pct + (96 - add_pct) / 2) op = OP_DEL;
        else if (r < 96) op = OP_REG;
        else op = OP_NONE;
        src = ($urandom_range(0, 3) != 0) ? src_pool[3'($urandom_range(0, 7))] : $urandom;
        sel = ($urandom_range(0, 3) != 0) ? SEL_W'($urandom_range(0, sel_hi))
                                          : SEL_W'($urandom_range(0, 255));
        offer_word(op, src, $urandom, sel, PORT_W'($urandom_range(0, 65535)),
                   KIND_W'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int words, input int add_pct, input int sel_hi);
        repeat (words) random_word(add_pct, sel_hi);
    endtask

    // sender goes quiet until every result is back
    task automatic settle(input int tail);
        word_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] max_word, input logic [CFG_W-1:0] exempt_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_CONNS;
        cfg_wdata <= max_word;
        @(posedge clk);
        cfg_index <= CFG_EXEMPT;
        cfg_wdata <= exempt_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : rx_side
        int seen;
        int holds;
        int run;
        seen  = 0;
        holds = 0;
        @(posedge clk);
        forever begin
            if ((holds == 0 && seen >= 40) || (holds == 1 && seen >= 600)) begin
                res_stall <= 1'b1;
                holds++;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                run = idle_run_len();
                if (run > 0) begin
                    res_stall <= 1'b1;
                    repeat (run) @(posedge clk);
                end
            end
            res_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : 1;
            repeat (run) begin
                @(posedge clk);
                if (res_valid && !res_stall) seen++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (word_valid && !word_stall) || (res_valid && !res_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("tb_connection_slot_table: done, errors");
            $finish;
        end
    end

    initial begin : tx_side
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) src_pool[i] = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: max-connections value 3 (a source may hold up to 4 slots), exempt address 0
        offer_word(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
        offer_word(OP_NONE, '0, '0, 8'h00, '0, '0);
        offer_word(OP_DEL, '0, '0, 8'h00, '0, '0);
        offer_word(OP_REG, '0, '0, 8'h00, 16'h1234, 8'h56);
        repeat (5) offer_word(OP_ADD, src_pool[2], $urandom, '0, '0, '0);
        offer_word(OP_ADD, 32'h0000_0000, 32'h0000_0000, '0, '0, '0);
        offer_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, '0, '0);
        offer_word(OP_REG, '0, '0, 8'h00, 16'hFFFF, 8'hFF);
        offer_word(OP_REG, '0, '0, 8'h00, 16'h0000, 8'h00);
        offer_word(OP_DEL, '0, '0, 8'h00, '0, '0);
        offer_word(OP_DEL, '0, '0, 8'h00, '0, '0);
        offer_word(OP_ADD, src_pool[2], $urandom, '0, '0, '0);
        offer_word(OP_DEL, '0, '0, 8'hFF, '0, '0);
        offer_word(OP_REG, '0, '0, 8'h06, PORT_W'($urandom_range(0, 65535)),
                   KIND_W'($urandom_range(0, 255)));
        offer_word(OP_DEL, '0, '0, 8'h06, '0, '0);
        offer_word(OP_REG, '0, '0, 8'h80, PORT_W'($urandom_range(0, 65535)),
                   KIND_W'($urandom_range(0, 255)));
        settle(8);

        set_limits((32'($urandom) & 32'hFFFF_FE00) | 32'd3, src_pool[2]);
        run_phase(220, 45, 40);
        settle(8);
        set_limits(32'd0, 32'hFFFF_FFFF);
        run_phase(200, 50, 40);
        settle(8);
        // no per-source limit: drives the table to full
        set_limits(32'd256, 32'd0);
        run_phase(330, 90, 63);
        settle(8);
        set_limits($urandom_range(1, 8), src_pool[3'($urandom_range(2, 7))]);
        run_phase(250, 30, 255);
        settle(8);
        set_limits(32'd1, $urandom);
        run_phase(150, 45, 63);
        settle(DRAIN_TAIL);

        if (fail_count == 0) $display("tb_connection_slot_table: done, clean");
        else $display("tb_connection_slot_table: done, errors");
        $finish;
    end

endmodule

// ===== connection_slot_table.f =====
design/cst_pkg.sv
design/cst_ram.sv
design/cst_ctrl.sv
design/connection_slot_table.sv
tb/cst_result_check.sv
tb/tb_connection_slot_table.sv
